### design/tsrb_pkg.sv
`default_nettype none

package tsrb_pkg;

   // field widths of the request and response beats
   localparam int MODE_W    = 2;
   localparam int PAYLOAD_W = 64;
   localparam int TIME_W    = 64;
   localparam int SLOT_W    = 10;
   localparam int STATUS_W  = 2;
   localparam int SEQ_W     = 32;

   // request modes
   localparam logic [MODE_W-1:0] MODE_PUBLISH = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CONSUME = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PEEK    = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   // a stable slot's sequence count rises by this much per publish
   localparam logic [SEQ_W-1:0] SEQ_STEP = 32'd2;

   // what the back end has to do with a classified beat
   typedef enum logic [1:0] {
      OP_NONE,
      OP_WRITE,
      OP_READ
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [STATUS_W-1:0]   status;
      logic                  fresh;   // slot never published, sequence count reads as zero
   } cmd_type;

   typedef enum logic {
      BK_IDLE,
      BK_FINISH
   } back_state_type;

endpackage

`default_nettype wire

### design/timestamped_ring_buffer.sv
// channel   direction  handshake              payload
// req_      in         req_valid / req_ready  mode, payload, time_ns, slot_index
// rsp_      out        rsp_valid / rsp_ready  status, message_bytes, message_time, slot_seq
//
// each request beat gives exactly one response beat, in request order
// the back end finishes each beat before it takes the next: the registered read of the slot
// stores, then the sequence count write-back and the response register load
// a request beat is taken while the two-entry command queue has room
// reset clears the counters and the queue, no pass over the slot stores is needed
// a stalled response holds the back end, which then fills the queue and stalls requests
`default_nettype none

module timestamped_ring_buffer #(
   parameter int DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [tsrb_pkg::MODE_W-1:0]         req_mode,
   input  logic [tsrb_pkg::PAYLOAD_W-1:0]      req_payload,
   input  logic [tsrb_pkg::TIME_W-1:0]         req_time_ns,
   input  logic [tsrb_pkg::SLOT_W-1:0]         req_slot_index,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [tsrb_pkg::STATUS_W-1:0]       rsp_status,
   output logic [tsrb_pkg::PAYLOAD_W-1:0]      rsp_message_bytes,
   output logic [tsrb_pkg::TIME_W-1:0]         rsp_message_time,
   output logic [tsrb_pkg::SEQ_W-1:0]          rsp_slot_seq
);
   import tsrb_pkg::*;

   // the user must keep depth a power of two (the block does not enforce it) so slot numbers are the low count bits
   localparam int AW = $clog2(DEPTH);
   localparam int CW = AW + 1;
   localparam int QW = $bits(cmd_type) + AW + PAYLOAD_W + TIME_W;

   // front end classifies the beat and moves the counters at accept time
   logic          push_valid, push_ready;
   cmd_type       push_cmd;
   logic [AW-1:0] push_addr;
   logic [CW-1:0] ring_level;

   // queue head as seen by the back end
   logic                 cmd_valid, cmd_pop;
   cmd_type              cmd;
   logic [AW-1:0]        cmd_addr;
   logic [PAYLOAD_W-1:0] cmd_payload;
   logic [TIME_W-1:0]    cmd_time;
   logic [QW-1:0]        q_in_data, q_out_data;

   tsrb_front #(
      .DEPTH (DEPTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_slot_index (req_slot_index),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_cmd       (push_cmd),
      .push_addr      (push_addr),
      .ring_level     (ring_level)
   );

   // payload and timestamp travel with the command so the back end writes them
   assign q_in_data = {push_cmd, push_addr, req_payload, req_time_ns};

   tsrb_queue #(
      .W (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (q_in_data),
      .out_valid (cmd_valid),
      .out_ready (cmd_pop),
      .out_data  (q_out_data)
   );

   assign {cmd, cmd_addr, cmd_payload, cmd_time} = q_out_data;

   // back end owns the slot stores and the response register
   tsrb_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (cmd_valid),
      .cmd_pop           (cmd_pop),
      .cmd               (cmd),
      .cmd_addr          (cmd_addr),
      .cmd_payload       (cmd_payload),
      .cmd_time          (cmd_time),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_message_bytes (rsp_message_bytes),
      .rsp_message_time  (rsp_message_time),
      .rsp_slot_seq      (rsp_slot_seq)
   );

`ifndef SYNTH
   // unread messages never exceed the ring depth
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      ring_level <= CW'(DEPTH))
      else $error("ring level above depth");

   // the counters move only on an accepted request beat
   a_level_quiet: assert property (@(posedge clock) disable iff (reset)
      !(req_valid && req_ready) |=> $stable(ring_level))
      else $error("ring level moved without a request beat");

   // the back end only takes a command that the queue holds
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command popped from empty queue");
`endif

endmodule

`default_nettype wire

### design/tsrb_front.sv
`default_nettype none

module tsrb_front #(
   parameter  int DEPTH = 1024,
   localparam int AW    = $clog2(DEPTH),
   localparam int CW    = AW + 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [tsrb_pkg::MODE_W-1:0]      req_mode,
   input  logic [tsrb_pkg::SLOT_W-1:0]      req_slot_index,
   output logic                             push_valid,
   input  logic                             push_ready,
   output tsrb_pkg::cmd_type                push_cmd,
   output logic [AW-1:0]                    push_addr,
   output logic [CW-1:0]                    ring_level
);
   import tsrb_pkg::*;

   logic [CW-1:0]        wr_count_ff, wr_count_in;
   logic [CW-1:0]        rd_count_ff, rd_count_in;
   logic                 filled_ff, filled_in;
   logic [AW+SLOT_W-1:0] peek_wide;
   logic [AW-1:0]        wr_slot, rd_slot, peek_slot;
   logic                 accept, full, empty;

   assign wr_slot    = wr_count_ff[AW-1:0];
   assign rd_slot    = rd_count_ff[AW-1:0];
   assign peek_wide  = (AW+SLOT_W)'(req_slot_index);
   assign peek_slot  = peek_wide[AW-1:0];
   assign ring_level = wr_count_ff - rd_count_ff;
   assign full       = ring_level[AW];
   assign empty      = (ring_level == '0);

   assign push_valid = req_valid;
   assign req_ready  = push_ready;
   assign accept     = req_valid && push_ready;

   always_comb begin
      push_cmd.op     = OP_NONE;
      push_cmd.status = STATUS_OK;
      push_cmd.fresh  = 1'b0;
      push_addr       = '0;
      wr_count_in     = wr_count_ff;
      rd_count_in     = rd_count_ff;
      filled_in       = filled_ff;
      case (req_mode)
         MODE_PUBLISH: begin
            if (full) begin
               push_cmd.status = STATUS_FULL;
            end else begin
               push_cmd.op    = OP_WRITE;
               push_cmd.fresh = !filled_ff;
               push_addr      = wr_slot;
               if (accept) begin
                  wr_count_in = wr_count_ff + 1'b1;
                  // every slot has been published once the count first wraps
                  if (wr_count_in[AW-1:0] == '0) begin
                     filled_in = 1'b1;
                  end
               end
            end
         end
         MODE_CONSUME: begin
            if (empty) begin
               push_cmd.status = STATUS_EMPTY;
            end else begin
               // an unread slot has always been published
               push_cmd.op = OP_READ;
               push_addr   = rd_slot;
               if (accept) begin
                  rd_count_in = rd_count_ff + 1'b1;
               end
            end
         end
         MODE_PEEK: begin
            push_cmd.op    = OP_READ;
            push_cmd.fresh = !filled_ff && (peek_slot >= wr_slot);
            push_addr      = peek_slot;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_count_ff <= '0;
         rd_count_ff <= '0;
         filled_ff   <= 1'b0;
      end else begin
         wr_count_ff <= wr_count_in;
         rd_count_ff <= rd_count_in;
         filled_ff   <= filled_in;
      end
   end

endmodule

`default_nettype wire

### design/tsrb_queue.sv
`default_nettype none

module tsrb_queue #(
   parameter int W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [W-1:0] out_data
);

   localparam int             ENTRIES    = 2;
   localparam logic [1:0]     FULL_COUNT = 2'(ENTRIES);

   logic [W-1:0] entry_ff [ENTRIES];
   logic [1:0]   count_ff, count_in;
   logic         head_ff, head_in;
   logic         tail_ff, tail_in;
   logic         push, pop;

   assign in_ready  = (count_ff != FULL_COUNT);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = entry_ff[head_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      head_in  = pop  ? !head_ff : head_ff;
      tail_in  = push ? !tail_ff : tail_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         head_ff  <= 1'b0;
         tail_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
      end
   end

endmodule

`default_nettype wire

### design/tsrb_back.sv
`default_nettype none

module tsrb_back #(
   parameter  int DEPTH = 1024,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                cmd_valid,
   output logic                                cmd_pop,
   input  tsrb_pkg::cmd_type                   cmd,
   input  logic [AW-1:0]                       cmd_addr,
   input  logic [tsrb_pkg::PAYLOAD_W-1:0]      cmd_payload,
   input  logic [tsrb_pkg::TIME_W-1:0]         cmd_time,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [tsrb_pkg::STATUS_W-1:0]       rsp_status,
   output logic [tsrb_pkg::PAYLOAD_W-1:0]      rsp_message_bytes,
   output logic [tsrb_pkg::TIME_W-1:0]         rsp_message_time,
   output logic [tsrb_pkg::SEQ_W-1:0]          rsp_slot_seq
);
   import tsrb_pkg::*;

   logic [PAYLOAD_W-1:0] payload_mem [DEPTH];
   logic [TIME_W-1:0]    time_mem    [DEPTH];
   logic [SEQ_W-1:0]     seq_mem     [DEPTH];

   back_state_type       state_ff, state_in;
   cmd_type              cmd_ff;
   logic [AW-1:0]        addr_ff;
   logic [PAYLOAD_W-1:0] rd_payload_ff;
   logic [TIME_W-1:0]    rd_time_ff;
   logic [SEQ_W-1:0]     rd_seq_ff;
   logic [SEQ_W-1:0]     cur_seq;

   logic                 rsp_valid_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [PAYLOAD_W-1:0] rsp_bytes_ff;
   logic [TIME_W-1:0]    rsp_time_ff;
   logic [SEQ_W-1:0]     rsp_seq_ff;

   logic                 out_free, rsp_load, seq_we, data_we;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign cur_seq  = cmd_ff.fresh ? '0 : rd_seq_ff;
   assign data_we  = cmd_pop && (cmd.op == OP_WRITE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE:   if (cmd_valid) state_in = BK_FINISH;
         BK_FINISH: if (out_free)  state_in = BK_IDLE;
         default:   state_in = BK_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      cmd_pop  = 1'b0;
      rsp_load = 1'b0;
      seq_we   = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            cmd_pop = cmd_valid;
         end
         BK_FINISH: begin
            rsp_load = out_free;
            seq_we   = out_free && (cmd_ff.op == OP_WRITE);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (data_we) begin
         payload_mem[cmd_addr] <= cmd_payload;
      end
      if (cmd_pop) begin
         rd_payload_ff <= payload_mem[cmd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (data_we) begin
         time_mem[cmd_addr] <= cmd_time;
      end
      if (cmd_pop) begin
         rd_time_ff <= time_mem[cmd_addr];
      end
   end

   // read-modify-write of the sequence count, the write follows the registered read in the finish state
   always_ff @(posedge clock) begin
      if (seq_we) begin
         seq_mem[addr_ff] <= cur_seq + SEQ_STEP;
      end
      if (cmd_pop) begin
         rd_seq_ff <= seq_mem[cmd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         cmd_ff  <= cmd;
         addr_ff <= cmd_addr;
      end
      if (rsp_load) begin
         rsp_status_ff <= cmd_ff.status;
         if (cmd_ff.op == OP_READ) begin
            rsp_bytes_ff <= rd_payload_ff;
            rsp_time_ff  <= rd_time_ff;
            rsp_seq_ff   <= cur_seq;
         end else begin
            rsp_bytes_ff <= '0;
            rsp_time_ff  <= '0;
            rsp_seq_ff   <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_message_bytes = rsp_bytes_ff;
   assign rsp_message_time  = rsp_time_ff;
   assign rsp_slot_seq      = rsp_seq_ff;

endmodule

`default_nettype wire
